// File: hdl/priority_key_mode_selector_assert.svh
// ----------------------------------------------------------------------------
// Priority key mode selector assertion macros
// Property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_KEY_MODE_SELECTOR_ASSERT_SVH
`define PRIORITY_KEY_MODE_SELECTOR_ASSERT_SVH

// same-cycle implication
`define PKMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PKMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pkms_pkg.sv
// ----------------------------------------------------------------------------
// Priority key mode selector package
// Sizes, field widths, slot mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pkms_pkg;

  localparam int SLOTS   = 8;
  localparam int KEYS    = 16;
  localparam int PRESETS = 8;

  localparam int MASK_W     = 16;
  localparam int KEY_W      = 4;
  localparam int MODE_W     = 2;
  localparam int PRESET_W   = 3;
  localparam int CNT_W      = 4;
  localparam int PHASE_W    = 2;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

  localparam int SLOT_KEYS_W    = 32;
  localparam int SLOT_MODES_W   = 16;
  localparam int SLOT_PRESETS_W = 24;

  localparam int TURBO_PERIOD = 3;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_TURBO   = 2'd1,
    MODE_TOGGLE  = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLOT_COUNT   = 2'd0,
    CFG_SLOT_KEYS    = 2'd1,
    CFG_SLOT_MODES   = 2'd2,
    CFG_SLOT_PRESETS = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: hdl/priority_key_mode_selector.sv
// The result registers when the scan reaches the winning slot s, or after it passes all
// count slots when no slot fires; the scan holds while a result waits on out_tready.
// A single slot evaluation unit visits one slot per cycle while the output is free, and
// in_tready is low during the scan, so a new frame waits until the result is registered.
// Reset: clears the configuration, the per-key edge, latch and turbo state, and the
// result valid flag; the state returns to idle, so the block is ready once reset ends.
// ----------------------------------------------------------------------------
// Priority key mode selector
// Scans configured slots in order per frame and reports the first firing preset, or no override when none fires.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_key_mode_selector_assert.svh"

module priority_key_mode_selector (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [pkms_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] pressed_mask
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [pkms_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [2:0] preset_index
  output logic [pkms_pkg::OUT_TUSER_W-1:0]        out_tuser,  // [0] override_valid
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pkms_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pkms_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                                 state_r, state_nxt;
  logic [pkms_pkg::SLOT_CNT_W-1:0]        slot_r, slot_nxt;
  logic [pkms_pkg::SLOT_CNT_W-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic [pkms_pkg::MASK_W-1:0]            mask_r, mask_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  logic                                   ovr_r, ovr_nxt;
  logic [pkms_pkg::PRESET_W-1:0]          preset_r, preset_nxt;

  logic [pkms_pkg::CNT_W-1:0]             slot_count_r;
  logic [pkms_pkg::SLOT_KEYS_W-1:0]       slot_keys_r;
  logic [pkms_pkg::SLOT_MODES_W-1:0]      slot_modes_r;
  logic [pkms_pkg::SLOT_PRESETS_W-1:0]    slot_presets_r;

  logic                                   prev_r  [pkms_pkg::KEYS];
  logic                                   latch_r [pkms_pkg::KEYS];
  logic [pkms_pkg::PHASE_W-1:0]           phase_r [pkms_pkg::KEYS];

  logic [pkms_pkg::SLOT_W-1:0]            slot_idx;
  logic [pkms_pkg::KEY_W-1:0]             key;
  pkms_pkg::mode_t                        mode;
  logic [pkms_pkg::PRESET_W-1:0]          preset_raw;
  logic [pkms_pkg::PRESET_W-1:0]          preset_sel;
  logic [pkms_pkg::SLOT_CNT_W-1:0]        cnt_eff;
  logic                                   key_in_range;
  logic                                   held;
  logic                                   fire;
  logic                                   out_free;
  logic                                   step_en;
  logic [pkms_pkg::PHASE_W:0]             phase_sum;
  logic [pkms_pkg::PHASE_W-1:0]           phase_nxt;
  logic                                   phase_we;
  logic                                   latch_nxt;
  logic                                   toggle_we;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = pkms_pkg::OUT_TDATA_W'(preset_r);
  assign out_tuser  = ovr_r;

  assign out_free = !out_valid_r || out_tready;
  assign step_en  = (state_r == ST_SCAN) && out_free && (slot_r != scan_cnt_r);

  assign cnt_eff = (int'(slot_count_r) > pkms_pkg::SLOTS) ?
                   pkms_pkg::SLOT_CNT_W'(pkms_pkg::SLOTS) :
                   pkms_pkg::SLOT_CNT_W'(slot_count_r);

  // slot field selection
  assign slot_idx   = slot_r[pkms_pkg::SLOT_W-1:0];
  assign key        = slot_keys_r[int'(slot_idx)*pkms_pkg::KEY_W +: pkms_pkg::KEY_W];
  assign mode       = pkms_pkg::mode_t'(
                        slot_modes_r[int'(slot_idx)*pkms_pkg::MODE_W +: pkms_pkg::MODE_W]);
  assign preset_raw = slot_presets_r[int'(slot_idx)*pkms_pkg::PRESET_W +: pkms_pkg::PRESET_W];
  assign preset_sel = (int'(preset_raw) >= pkms_pkg::PRESETS) ?
                      pkms_pkg::PRESET_W'(pkms_pkg::PRESETS - 1) : preset_raw;

  assign key_in_range = int'(key) < pkms_pkg::KEYS;
  assign held         = key_in_range && mask_r[key];

  // turbo phase advance: wrap at the period
  assign phase_sum = {1'b0, phase_r[key]} + 3'd1;

  always_comb begin
    fire      = 1'b0;
    phase_we  = 1'b0;
    phase_nxt = phase_r[key];
    toggle_we = 1'b0;
    latch_nxt = latch_r[key];
    case (mode)
      pkms_pkg::MODE_NORMAL: begin
        fire = held;
      end
      pkms_pkg::MODE_TURBO: begin
        if (held) begin
          phase_we = 1'b1;
          if (phase_r[key] == '0) begin
            fire      = 1'b1;
            phase_nxt = pkms_pkg::PHASE_W'(1);
          end else if (int'(phase_sum) >= pkms_pkg::TURBO_PERIOD) begin
            phase_nxt = pkms_pkg::PHASE_W'(phase_sum - 3'(pkms_pkg::TURBO_PERIOD));
          end else begin
            phase_nxt = pkms_pkg::PHASE_W'(phase_sum);
          end
        end
      end
      pkms_pkg::MODE_TOGGLE: begin
        if (key_in_range) begin
          toggle_we = 1'b1;
          latch_nxt = latch_r[key] ^ (held && !prev_r[key]);
          fire      = latch_nxt;
        end
      end
      pkms_pkg::MODE_REVERSE: begin
        fire = !held;
      end
      default: begin
        fire = !held;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    scan_cnt_nxt  = scan_cnt_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ovr_nxt       = ovr_r;
    preset_nxt    = preset_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mask_nxt     = in_tdata;
          slot_nxt     = '0;
          scan_cnt_nxt = cnt_eff;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (slot_r == scan_cnt_r) begin
            out_valid_nxt = 1'b1;
            ovr_nxt       = 1'b0;
            preset_nxt    = '0;
            state_nxt     = ST_IDLE;
          end else if (fire) begin
            out_valid_nxt = 1'b1;
            ovr_nxt       = 1'b1;
            preset_nxt    = preset_sel;
            state_nxt     = ST_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    mask_r     <= mask_nxt;
    ovr_r      <= ovr_nxt;
    preset_r   <= preset_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r   <= '0;
      slot_keys_r    <= '0;
      slot_modes_r   <= '0;
      slot_presets_r <= '0;
    end else if (cfg_valid) begin
      case (pkms_pkg::cfg_reg_t'(cfg_index))
        pkms_pkg::CFG_SLOT_COUNT:   slot_count_r   <= cfg_data[pkms_pkg::CNT_W-1:0];
        pkms_pkg::CFG_SLOT_KEYS:    slot_keys_r    <= cfg_data[pkms_pkg::SLOT_KEYS_W-1:0];
        pkms_pkg::CFG_SLOT_MODES:   slot_modes_r   <= cfg_data[pkms_pkg::SLOT_MODES_W-1:0];
        pkms_pkg::CFG_SLOT_PRESETS: slot_presets_r <= cfg_data[pkms_pkg::SLOT_PRESETS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < pkms_pkg::KEYS; k++) begin
        prev_r[k]  <= 1'b0;
        latch_r[k] <= 1'b0;
        phase_r[k] <= '0;
      end
    end else if (step_en) begin
      if (phase_we) begin
        phase_r[key] <= phase_nxt;
      end
      if (toggle_we) begin
        latch_r[key] <= latch_nxt;
        prev_r[key]  <= held;
      end
    end
  end

  `PKMS_ASSERT_NEXT(a_accept_starts_scan, in_tvalid && in_tready,
    state_r == ST_SCAN && slot_r == '0, "transfer did not start a scan at slot zero")
  `PKMS_ASSERT_NOW(a_slot_within_count, state_r == ST_SCAN,
    slot_r <= scan_cnt_r, "slot pointer passed the scan count")
  `PKMS_ASSERT_NOW(a_no_override_zero_preset, out_valid_r && !ovr_r,
    preset_r == '0, "result without override carries a nonzero preset")
  `PKMS_ASSERT_NEXT(a_fire_ends_scan, step_en && fire,
    state_r == ST_IDLE && out_valid_r, "firing slot did not end the scan")

endmodule

`default_nettype wire
